// ===== rtl/core/wzo_pkg.sv =====
// Shared types and constants for the window z-score outlier core.
// Used by window_zscore_outlier_core and wzo_checker; no dependencies.
package wzo_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned THR_BITS       = 12;
  // fractional bits of the Q4.8 threshold
  localparam int unsigned THR_FRAC       = 8;
  localparam int unsigned WINDOW_MAX_DEF = 256;

  localparam logic [THR_BITS-1:0] THR_RESET = 12'd768;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_EVAL  = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_FLAT  = 2'd2
  } status_e;

  // request kinds
  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_TEST = 1'b1
  } kind_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,    // waiting for a request
    ST_SQ,      // sum of squares += |v|^2
    ST_DIFF,    // d = n*v - sum
    ST_DSQ,     // d^2
    ST_DN,      // d^2 * (n-1)
    ST_SUMSQ,   // sum^2
    ST_SPREAD,  // n*sumsq - sum^2
    ST_SN,      // spread * n
    ST_TH1,     // * threshold
    ST_TH2,     // * threshold
    ST_DONE     // hand result to output register
  } state_e;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic    outlier;
    status_e status;
    logic    dropped;
  } out_rsp_t;

endpackage

// ===== rtl/core/window_zscore_outlier_core.sv =====
// Window z-score outlier detector: running window statistics and exact integer test.
// Depends on wzo_pkg; one shared shift-add multiply-accumulate unit does all products.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | in_valid_i/in_ready_o  | in_req_i  (kind, sample)
//  out      | output    | out_valid_o/out_ready_i| out_rsp_o (outlier, status, dropped)
//  cfg      | input     | cfg_we_i, no wait      | cfg_wdata_i (threshold Q4.8)
//
// The multiply unit retires one multiplier bit per cycle and stops when the remaining
// multiplier bits are zero. An added sample is squared with one product, or dropped
// when the window is full; a test on a short window needs no product, and a full
// evaluation chains eight products.
// Reset clears the window and loads threshold 3.0; no clearing pass is needed.
// in_ready_o is high only in the idle state. A finished result sits in the output
// register; a test that finishes while that register is still full holds until it drains.
module window_zscore_outlier_core #(
  parameter int unsigned WINDOW_MAX = wzo_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wzo_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wzo_pkg::out_rsp_t             out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [wzo_pkg::THR_BITS-1:0]  cfg_wdata_i
);
  import wzo_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SumW = SAMPLE_BITS + CntW;
  localparam int unsigned SqW  = 2 * SAMPLE_BITS - 2 + CntW;
  localparam int unsigned MulW = SAMPLE_BITS + CntW;
  localparam int unsigned AccW = 2 * SAMPLE_BITS + 3 * CntW + 2 * THR_BITS - 2;
  localparam int unsigned QSh  = 2 * THR_FRAC;

  localparam logic [CntW-1:0] WinFull = CntW'(WINDOW_MAX);
  localparam logic [CntW-1:0] MinWin  = CntW'(3);

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]         sumsq_q, sumsq_d;
  logic                   ovf_q, ovf_d;
  logic [THR_BITS-1:0]    thr_q;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [AccW-1:0]        mcand_q, mcand_d;
  logic [MulW-1:0]        mplier_q, mplier_d;
  logic [AccW-1:0]        lhs_q, lhs_d;
  logic                   res_outlier_q, res_outlier_d;
  status_e                res_status_q, res_status_d;
  logic                   out_valid_q, out_valid_d;
  out_rsp_t               out_rsp_q, out_rsp_d;

  logic                   in_fire;
  logic                   mul_busy;
  logic                   out_free;
  logic                   is_mul_state;
  logic [SumW-1:0]        sum_mag;
  logic [SAMPLE_BITS-1:0] v_mag;
  logic [AccW-1:0]        d_mag;
  logic [CntW-1:0]        n_minus1;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign mul_busy    = |mplier_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // magnitudes feeding the multiplier
  assign sum_mag  = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;
  assign v_mag    = in_req_i.sample[SAMPLE_BITS-1] ? (~in_req_i.sample + SAMPLE_BITS'(1))
                                                   : in_req_i.sample;
  assign d_mag    = acc_q[AccW-1] ? (~acc_q + AccW'(1)) : acc_q;
  assign n_minus1 = count_q - CntW'(1);

  assign is_mul_state = (state_q != ST_IDLE) && (state_q != ST_DONE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_i.kind == KIND_ADD) begin
            if (count_q < WinFull) state_d = ST_SQ;
          end else if (count_q < MinWin) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_SQ:     if (!mul_busy) state_d = ST_IDLE;
      ST_DIFF:   if (!mul_busy) state_d = ST_DSQ;
      ST_DSQ:    if (!mul_busy) state_d = ST_DN;
      ST_DN:     if (!mul_busy) state_d = ST_SUMSQ;
      ST_SUMSQ:  if (!mul_busy) state_d = ST_SPREAD;
      ST_SPREAD: begin
        if (!mul_busy) state_d = (acc_q == '0) ? ST_DONE : ST_SN;
      end
      ST_SN:     if (!mul_busy) state_d = ST_TH1;
      ST_TH1:    if (!mul_busy) state_d = ST_TH2;
      ST_TH2:    if (!mul_busy) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and window update
  always_comb begin
    count_d       = count_q;
    sum_d         = sum_q;
    sumsq_d       = sumsq_q;
    ovf_d         = ovf_q;
    acc_d         = acc_q;
    mcand_d       = mcand_q;
    mplier_d      = mplier_q;
    lhs_d         = lhs_q;
    res_outlier_d = res_outlier_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_rsp_d     = out_rsp_q;

    // shared shift-add step
    if (is_mul_state && mul_busy) begin
      acc_d    = acc_q + (mplier_q[0] ? mcand_q : '0);
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_i.kind == KIND_ADD) begin
            if (count_q < WinFull) begin
              // square accumulates straight onto the running sum of squares
              count_d  = count_q + CntW'(1);
              sum_d    = sum_q + SumW'(in_req_i.sample);
              acc_d    = AccW'(sumsq_q);
              mcand_d  = AccW'(v_mag);
              mplier_d = MulW'(v_mag);
            end else begin
              ovf_d = 1'b1;
            end
          end else if (count_q < MinWin) begin
            res_outlier_d = 1'b0;
            res_status_d  = STATUS_SHORT;
          end else begin
            // d = n*v - sum, starting from -sum
            acc_d    = '0 - AccW'(sum_q);
            mcand_d  = AccW'(in_req_i.sample);
            mplier_d = MulW'(count_q);
          end
        end
      end
      ST_SQ: begin
        if (!mul_busy) sumsq_d = acc_q[SqW-1:0];
      end
      ST_DIFF: begin
        if (!mul_busy) begin
          acc_d    = '0;
          mcand_d  = d_mag;
          mplier_d = d_mag[MulW-1:0];
        end
      end
      ST_DSQ: begin
        if (!mul_busy) begin
          acc_d    = '0;
          mcand_d  = acc_q;
          mplier_d = MulW'(n_minus1);
        end
      end
      ST_DN: begin
        if (!mul_busy) begin
          // scale for the Q4.8 threshold squared
          lhs_d    = {acc_q[AccW-QSh-1:0], {QSh{1'b0}}};
          acc_d    = '0;
          mcand_d  = AccW'(sum_mag);
          mplier_d = MulW'(sum_mag);
        end
      end
      ST_SUMSQ: begin
        if (!mul_busy) begin
          // n*sumsq accumulates onto -sum^2
          acc_d    = '0 - acc_q;
          mcand_d  = AccW'(sumsq_q);
          mplier_d = MulW'(count_q);
        end
      end
      ST_SPREAD: begin
        if (!mul_busy) begin
          if (acc_q == '0) begin
            res_outlier_d = 1'b0;
            res_status_d  = STATUS_FLAT;
          end else begin
            acc_d    = '0;
            mcand_d  = acc_q;
            mplier_d = MulW'(count_q);
          end
        end
      end
      ST_SN, ST_TH1: begin
        if (!mul_busy) begin
          acc_d    = '0;
          mcand_d  = acc_q;
          mplier_d = MulW'(thr_q);
        end
      end
      ST_TH2: begin
        if (!mul_busy) begin
          res_outlier_d = (lhs_q > acc_q);
          res_status_d  = STATUS_EVAL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_rsp_d.outlier = res_outlier_q;
          out_rsp_d.status  = res_status_q;
          out_rsp_d.dropped = ovf_q;
          // a test starts a fresh window
          count_d = '0;
          sum_d   = '0;
          sumsq_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      ovf_q       <= 1'b0;
      thr_q       <= THR_RESET;
      mplier_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      ovf_q       <= ovf_d;
      mplier_q    <= mplier_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  // arithmetic and result payload
  always_ff @(posedge clk_i) begin
    acc_q         <= acc_d;
    mcand_q       <= mcand_d;
    lhs_q         <= lhs_d;
    res_outlier_q <= res_outlier_d;
    res_status_q  <= res_status_d;
    out_rsp_q     <= out_rsp_d;
  end

endmodule

// ===== rtl/core/wzo_checker.sv =====
// Port-level checks for window_zscore_outlier_core, attached by bind.
// Depends on wzo_pkg for the request and response types.
module wzo_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input wzo_pkg::in_req_t              in_req_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input wzo_pkg::out_rsp_t             out_rsp_o,
  input logic                          cfg_we_i,
  input logic [wzo_pkg::THR_BITS-1:0]  cfg_wdata_i
);
  import wzo_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("result changed while stalled");

  // an accepted test request makes the block busy in the next cycle
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.kind == KIND_TEST) |=> !in_ready_o)
    else $error("ready high right after a test request");

  // a new result only appears after a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a test in progress");

  // special-case results never flag an outlier
  a_special_no_outlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != STATUS_EVAL) |-> !out_rsp_o.outlier)
    else $error("outlier flagged on short or flat window");

endmodule

bind window_zscore_outlier_core wzo_checker u_wzo_checker (.*);
